[src/qpt_pkg.sv]
// ----------------------------------------------------------------------------
// qpt_pkg
// shared types and constants of the quaternion point transform core
// ----------------------------------------------------------------------------
package qpt_pkg;

   localparam int unsigned WORD_BITS      = 32;
   localparam int unsigned QUAT_FRAC_BITS = 30;
   localparam int unsigned NUM_REGS       = 7;
   localparam int unsigned CSR_IDX_BITS   = 3;
   localparam int unsigned NUM_PRODS      = 10;
   localparam int unsigned NUM_ENTRIES    = 9;
   localparam int unsigned DIV_STEPS      = QUAT_FRAC_BITS + 2;

   // register indexes of the csr port
   localparam logic [CSR_IDX_BITS-1:0] REG_QUAT_X  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_QUAT_Y  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_QUAT_Z  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_QUAT_W  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_SHIFT_X = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_SHIFT_Y = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_SHIFT_Z = 3'd6;

   // product slots of the matrix sequencer
   localparam logic [3:0] PR_XX = 4'd0;
   localparam logic [3:0] PR_YY = 4'd1;
   localparam logic [3:0] PR_ZZ = 4'd2;
   localparam logic [3:0] PR_WW = 4'd3;
   localparam logic [3:0] PR_XY = 4'd4;
   localparam logic [3:0] PR_XZ = 4'd5;
   localparam logic [3:0] PR_YZ = 4'd6;
   localparam logic [3:0] PR_WX = 4'd7;
   localparam logic [3:0] PR_WY = 4'd8;
   localparam logic [3:0] PR_WZ = 4'd9;

   typedef enum logic [2:0] {
      MS_IDLE,
      MS_MUL,
      MS_SUM,
      MS_LOAD,
      MS_DIV
   } mstate_type;

endpackage

[src/quaternion_point_transform_core.sv]
// ----------------------------------------------------------------------------
// quaternion_point_transform_core
// rotates one Q16.16 point per word by a normalized quaternion and translates it
// ----------------------------------------------------------------------------
// Throughput is one point word per clock unless rsp_stall holds the pipe
// or the matrix is being rebuilt; each word passes the multiply, row sum
// and round/translate/saturate stages. The rotation matrix is not built
// per point: after reset and after every csr write a sequencer rebuilds it
// with one shared 32x32 multiplier, one sum step and one restoring divider
// that works the nine entries in turn. Until it finishes req_stall is held
// high. csr writes are always taken (csr_ready is tied high) and restart
// the build. An all-zero quaternion gives zero coordinates and bad_rotation.
module quaternion_point_transform_core
   import qpt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // point words in
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [31:0]       req_point_x,
   input  logic signed [31:0]       req_point_y,
   input  logic signed [31:0]       req_point_z,
   input  logic        [31:0]       req_point_intensity,
   // transformed words out
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_out_x,
   output logic signed [31:0]       rsp_out_y,
   output logic signed [31:0]       rsp_out_z,
   output logic        [31:0]       rsp_out_intensity,
   output logic                     rsp_bad_rotation,
   output logic                     rsp_clipped,
   // register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [31:0]              csr_data
);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic signed [31:0] quat_ff [4];
   logic signed [31:0] shift_ff [3];
   logic               csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff[0]  <= '0;
         quat_ff[1]  <= '0;
         quat_ff[2]  <= '0;
         quat_ff[3]  <= 32'sh4000_0000;
         shift_ff[0] <= '0;
         shift_ff[1] <= '0;
         shift_ff[2] <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_QUAT_X:  quat_ff[0]  <= csr_data;
            REG_QUAT_Y:  quat_ff[1]  <= csr_data;
            REG_QUAT_Z:  quat_ff[2]  <= csr_data;
            REG_QUAT_W:  quat_ff[3]  <= csr_data;
            REG_SHIFT_X: shift_ff[0] <= csr_data;
            REG_SHIFT_Y: shift_ff[1] <= csr_data;
            REG_SHIFT_Z: shift_ff[2] <= csr_data;
            default: ;  // writes past the last register are dropped
         endcase
      end
   end

   // all-zero quaternion: rotation undefined
   logic bad_rot;
   assign bad_rot = (quat_ff[0] == '0) && (quat_ff[1] == '0) &&
                    (quat_ff[2] == '0) && (quat_ff[3] == '0);

   // halve all four components when any lies outside [-1.0, 1.0] so every
   // product stays inside 64 bits
   logic               big_q;
   logic signed [31:0] qs [4];
   always_comb begin
      big_q = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (quat_ff[i] > 32'sh4000_0000 || quat_ff[i] < -32'sh4000_0000) begin
            big_q = 1'b1;
         end
      end
      for (int i = 0; i < 4; i++) begin
         qs[i] = big_q ? (quat_ff[i] >>> 1) : quat_ff[i];
      end
   end

   // ---------------------------------------------------------------------
   // matrix build sequencer
   // ---------------------------------------------------------------------
   mstate_type          mstate_ff, mstate_in;
   logic [3:0]          mul_cnt_ff;
   logic [3:0]          ent_cnt_ff;
   logic [4:0]          step_cnt_ff;
   logic signed [63:0]  prod_ff [NUM_PRODS];
   logic signed [63:0]  num_ff [NUM_ENTRIES];
   logic        [63:0]  n2_ff;
   logic        [63:0]  rem_ff;
   logic        [31:0]  quo_ff;
   logic                neg_ff;
   logic signed [31:0]  mat_ff [NUM_ENTRIES];
   logic                busy;
   logic                do_mul, do_sum, do_load, do_step;

   // next state
   always_comb begin
      mstate_in = mstate_ff;
      unique case (mstate_ff)
         MS_IDLE: mstate_in = MS_IDLE;
         MS_MUL:  if (mul_cnt_ff == 4'(NUM_PRODS - 1)) mstate_in = MS_SUM;
         MS_SUM:  mstate_in = MS_LOAD;
         MS_LOAD: mstate_in = MS_DIV;
         MS_DIV: begin
            if (step_cnt_ff == 5'(DIV_STEPS - 1)) begin
               mstate_in = (ent_cnt_ff == 4'(NUM_ENTRIES - 1)) ? MS_IDLE : MS_LOAD;
            end
         end
         default: mstate_in = MS_IDLE;
      endcase
      if (csr_wr) begin
         mstate_in = MS_MUL;
      end
   end

   // outputs of the sequencer
   always_comb begin
      do_mul  = 1'b0;
      do_sum  = 1'b0;
      do_load = 1'b0;
      do_step = 1'b0;
      unique case (mstate_ff)
         MS_IDLE: ;
         MS_MUL:  do_mul  = 1'b1;
         MS_SUM:  do_sum  = 1'b1;
         MS_LOAD: do_load = 1'b1;
         MS_DIV:  do_step = 1'b1;
         default: ;
      endcase
   end

   assign busy = (mstate_ff != MS_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mstate_ff   <= MS_MUL;
         mul_cnt_ff  <= '0;
         ent_cnt_ff  <= '0;
         step_cnt_ff <= '0;
      end else begin
         mstate_ff <= mstate_in;
         if (csr_wr) begin
            mul_cnt_ff  <= '0;
            ent_cnt_ff  <= '0;
            step_cnt_ff <= '0;
         end else begin
            if (do_mul) mul_cnt_ff <= mul_cnt_ff + 4'd1;
            if (do_step) begin
               if (step_cnt_ff == 5'(DIV_STEPS - 1)) begin
                  step_cnt_ff <= '0;
                  ent_cnt_ff  <= ent_cnt_ff + 4'd1;
               end else begin
                  step_cnt_ff <= step_cnt_ff + 5'd1;
               end
            end
         end
      end
   end

   // shared multiplier for the ten quaternion products
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   always_comb begin
      case (mul_cnt_ff)
         PR_XX:   begin mul_a = qs[0]; mul_b = qs[0]; end
         PR_YY:   begin mul_a = qs[1]; mul_b = qs[1]; end
         PR_ZZ:   begin mul_a = qs[2]; mul_b = qs[2]; end
         PR_WW:   begin mul_a = qs[3]; mul_b = qs[3]; end
         PR_XY:   begin mul_a = qs[0]; mul_b = qs[1]; end
         PR_XZ:   begin mul_a = qs[0]; mul_b = qs[2]; end
         PR_YZ:   begin mul_a = qs[1]; mul_b = qs[2]; end
         PR_WX:   begin mul_a = qs[3]; mul_b = qs[0]; end
         PR_WY:   begin mul_a = qs[3]; mul_b = qs[1]; end
         PR_WZ:   begin mul_a = qs[3]; mul_b = qs[2]; end
         default: begin mul_a = '0;    mul_b = '0;    end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (do_mul && mul_cnt_ff < 4'(NUM_PRODS)) begin
         prod_ff[mul_cnt_ff] <= mul_p;
      end
   end

   // numerators of the nine entries and the norm squared
   always_ff @(posedge clock) begin
      if (do_sum) begin
         num_ff[0] <= prod_ff[PR_WW] + prod_ff[PR_XX] - prod_ff[PR_YY] - prod_ff[PR_ZZ];
         num_ff[1] <= (prod_ff[PR_XY] - prod_ff[PR_WZ]) <<< 1;
         num_ff[2] <= (prod_ff[PR_XZ] + prod_ff[PR_WY]) <<< 1;
         num_ff[3] <= (prod_ff[PR_XY] + prod_ff[PR_WZ]) <<< 1;
         num_ff[4] <= prod_ff[PR_WW] - prod_ff[PR_XX] + prod_ff[PR_YY] - prod_ff[PR_ZZ];
         num_ff[5] <= (prod_ff[PR_YZ] - prod_ff[PR_WX]) <<< 1;
         num_ff[6] <= (prod_ff[PR_XZ] - prod_ff[PR_WY]) <<< 1;
         num_ff[7] <= (prod_ff[PR_YZ] + prod_ff[PR_WX]) <<< 1;
         num_ff[8] <= prod_ff[PR_WW] - prod_ff[PR_XX] - prod_ff[PR_YY] + prod_ff[PR_ZZ];
         n2_ff     <= 64'(prod_ff[PR_XX] + prod_ff[PR_YY] + prod_ff[PR_ZZ] + prod_ff[PR_WW]);
      end
   end

   // restoring divider: one quotient bit per cycle, first the integer bit,
   // then one extra fraction bit for the round half away from zero
   logic signed [63:0] num_sel;
   logic        [63:0] rem_sh;
   logic        [63:0] rem_in;
   logic        [31:0] quo_in;
   logic        [32:0] quo_rnd;
   logic        [31:0] mag_rnd;

   always_comb begin
      num_sel = (ent_cnt_ff < 4'(NUM_ENTRIES)) ? num_ff[ent_cnt_ff] : '0;
      rem_sh  = (step_cnt_ff == '0) ? rem_ff : {rem_ff[62:0], 1'b0};
      if (rem_sh >= n2_ff) begin
         rem_in = rem_sh - n2_ff;
         quo_in = {quo_ff[30:0], 1'b1};
      end else begin
         rem_in = rem_sh;
         quo_in = {quo_ff[30:0], 1'b0};
      end
      quo_rnd = {1'b0, quo_in} + 33'd1;
      mag_rnd = quo_rnd[32:1];
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         neg_ff <= num_sel[63];
         rem_ff <= num_sel[63] ? 64'(-num_sel) : 64'(num_sel);
         quo_ff <= '0;
      end else if (do_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         if (step_cnt_ff == 5'(DIV_STEPS - 1) && ent_cnt_ff < 4'(NUM_ENTRIES)) begin
            mat_ff[ent_cnt_ff] <= neg_ff ? -$signed(mag_rnd) : $signed(mag_rnd);
         end
      end
   end

   // ---------------------------------------------------------------------
   // point pipeline: multiply, row sum, round/translate/saturate
   // ---------------------------------------------------------------------
   logic               v1_ff, v2_ff, v3_ff;
   logic               en1, en2, en3;
   logic               req_acc;
   logic signed [63:0] pm_ff [NUM_ENTRIES];
   logic        [31:0] int1_ff, int2_ff;
   logic signed [63:0] acc_ff [3];
   logic signed [31:0] pin [3];
   logic signed [31:0] out_in [3];
   logic        [2:0]  clip_in;

   // a stage moves when its successor is empty or moving
   assign en3       = !v3_ff || !rsp_stall;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = busy || !en1;
   assign req_acc   = req_valid && !req_stall;

   assign pin[0] = req_point_x;
   assign pin[1] = req_point_y;
   assign pin[2] = req_point_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_acc;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // stage 1: nine entry-by-coordinate products
   always_ff @(posedge clock) begin
      if (en1) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            pm_ff[i] <= mat_ff[i] * pin[i % 3];
         end
         int1_ff <= req_point_intensity;
      end
   end

   // stage 2: row sums plus half an lsb of the point format
   always_ff @(posedge clock) begin
      if (en2) begin
         for (int r = 0; r < 3; r++) begin
            acc_ff[r] <= pm_ff[3*r] + pm_ff[3*r+1] + pm_ff[3*r+2] +
                         (64'sd1 <<< (QUAT_FRAC_BITS - 1));
         end
         int2_ff <= int1_ff;
      end
   end

   // stage 3: drop the fraction, translate, clamp to 32 bits; zero on a bad rotation
   always_comb begin
      logic signed [63:0] shr;
      logic signed [34:0] sum;
      for (int r = 0; r < 3; r++) begin
         shr = acc_ff[r] >>> QUAT_FRAC_BITS;
         sum = 35'(shr) + 35'(shift_ff[r]);
         if (bad_rot) begin
            out_in[r]  = '0;
            clip_in[r] = 1'b0;
         end else if (sum > 35'sh0_7FFF_FFFF) begin
            out_in[r]  = 32'sh7FFF_FFFF;
            clip_in[r] = 1'b1;
         end else if (sum < -35'sh0_8000_0000) begin
            out_in[r]  = -32'sh8000_0000;
            clip_in[r] = 1'b1;
         end else begin
            out_in[r]  = sum[31:0];
            clip_in[r] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         rsp_out_x         <= out_in[0];
         rsp_out_y         <= out_in[1];
         rsp_out_z         <= out_in[2];
         rsp_out_intensity <= int2_ff;
         rsp_bad_rotation  <= bad_rot;
         rsp_clipped       <= |clip_in;
      end
   end

   assign rsp_valid = v3_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // a register write restarts the matrix build, so no point may enter next
   a_wr_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> req_stall)
      else $error("point accepted right after a register write");

   // a zero quaternion gives a zero point that never reports clipping
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_rotation) |->
      (rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_z == '0 && !rsp_clipped))
      else $error("bad rotation word carries nonzero data");

   // the divider never runs past the last matrix entry
   a_ent_range: assert property (@(posedge clock) disable iff (reset)
      (mstate_ff == MS_DIV || mstate_ff == MS_LOAD) |-> ent_cnt_ff < 4'(NUM_ENTRIES))
      else $error("matrix entry counter out of range");

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench of the quaternion point transform core
// ----------------------------------------------------------------------------
// A directed table is played first. Some rows carry a hand-written expected
// word. The rest are checked against a bit-accurate predictor of the
// rotation, translation and saturation. Random phases follow with register
// sets rewritten between segments, sender and receiver idle at random in two.
module tb_top;
   import qpt_pkg::*;

   // index past the register file, writes there are dropped
   localparam logic [CSR_IDX_BITS-1:0] REG_NONE = 3'd7;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SEG_WORDS      = 40;
   localparam int PHASE_WORDS    = 330;

   typedef struct packed {
      logic [31:0] x, y, z, inten;
      logic        bad, clip;
   } xform_word_type;

   typedef struct {
      bit                      is_wr;   // register write row
      bit                      typed;   // expected word typed in below
      logic [CSR_IDX_BITS-1:0] idx;
      logic [31:0]             data;
      logic [31:0]             px, py, pz, pi;
      logic [31:0]             ex, ey, ez;
      bit                      eb, ec;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic [31:0] req_point_intensity = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [31:0] rsp_out_intensity;
   logic rsp_bad_rotation, rsp_clipped;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   quaternion_point_transform_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of the register file
   logic [31:0] quat_reg [4];
   logic [31:0] shift_reg [3];

   xform_word_type expected_words[$];
   int errors = 0;
   int words_sent = 0, words_seen = 0, reg_writes = 0;
   int clip_seen = 0, bad_seen = 0;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int quiet_cycles = 0;

   // one matrix entry: num/n2 to 30 fraction bits, half away from zero
   function automatic longint entry_q30(longint num, longint unsigned n2);
      longint unsigned mag, v, r;
      mag = (num < 0) ? longint'(-num) : num;
      v = mag / n2;
      r = mag % n2;
      for (int i = 0; i < QUAT_FRAC_BITS + 1; i++) begin
         r = r << 1;
         v = v << 1;
         if (r >= n2) begin
            r = r - n2;
            v = v | 1;
         end
      end
      v = (v + 1) >> 1;
      return (num < 0) ? -longint'(v) : longint'(v);
   endfunction

   function automatic xform_word_type rotate_translate(logic [31:0] px, logic [31:0] py,
                                                       logic [31:0] pz, logic [31:0] pi);
      xform_word_type res;
      longint q[4];
      longint m[9];
      longint p[3];
      longint unsigned n2;
      longint acc, v;
      bit big;
      res = '0;
      res.inten = pi;
      for (int k = 0; k < 4; k++) q[k] = longint'(signed'(quat_reg[k]));
      if (q[0] == 0 && q[1] == 0 && q[2] == 0 && q[3] == 0) begin
         res.bad = 1'b1;
         return res;
      end
      big = 1'b0;
      for (int k = 0; k < 4; k++)
         if (q[k] > (64'sd1 << 30) || q[k] < -(64'sd1 << 30)) big = 1'b1;
      // halve all components so products stay inside 64 bits
      if (big) for (int k = 0; k < 4; k++) q[k] = q[k] >>> 1;
      n2 = q[0]*q[0] + q[1]*q[1] + q[2]*q[2] + q[3]*q[3];
      m[0] = entry_q30(q[3]*q[3] + q[0]*q[0] - q[1]*q[1] - q[2]*q[2], n2);
      m[1] = entry_q30(2 * (q[0]*q[1] - q[3]*q[2]), n2);
      m[2] = entry_q30(2 * (q[0]*q[2] + q[3]*q[1]), n2);
      m[3] = entry_q30(2 * (q[0]*q[1] + q[3]*q[2]), n2);
      m[4] = entry_q30(q[3]*q[3] - q[0]*q[0] + q[1]*q[1] - q[2]*q[2], n2);
      m[5] = entry_q30(2 * (q[1]*q[2] - q[3]*q[0]), n2);
      m[6] = entry_q30(2 * (q[0]*q[2] - q[3]*q[1]), n2);
      m[7] = entry_q30(2 * (q[1]*q[2] + q[3]*q[0]), n2);
      m[8] = entry_q30(q[3]*q[3] - q[0]*q[0] - q[1]*q[1] + q[2]*q[2], n2);
      p[0] = longint'(signed'(px));
      p[1] = longint'(signed'(py));
      p[2] = longint'(signed'(pz));
      for (int row = 0; row < 3; row++) begin
         acc = m[row*3]*p[0] + m[row*3+1]*p[1] + m[row*3+2]*p[2];
         // round half up to the point format, arithmetic shift is a floor
         v = ((acc + (64'sd1 << (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS)
             + longint'(signed'(shift_reg[row]));
         if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
            res.clip = 1'b1;
         end else if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
            res.clip = 1'b1;
         end
         case (row)
            0: res.x = v[31:0];
            1: res.y = v[31:0];
            default: res.z = v[31:0];
         endcase
      end
      return res;
   endfunction

   // wait until every expected word is back, then let the pipe settle
   task automatic drain();
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // register write, only issued while the core is drained
   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      if (idx < REG_SHIFT_X) quat_reg[idx[1:0]] = data;
      else if (idx != REG_NONE) shift_reg[2'(idx - REG_SHIFT_X)] = data;
      reg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one point word, called on a falling edge; typed rows push their own
   // expectation, and a following call at once keeps the words back to back
   task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [31:0] pi, bit typed, xform_word_type typed_exp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_point_x = px;
      req_point_y = py;
      req_point_z = pz;
      req_point_intensity = pi;
      do @(posedge clock); while (req_stall);
      expected_words.insert(expected_words.size(),
                            typed ? typed_exp : rotate_translate(px, py, pz, pi));
      words_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic logic [31:0] rand_quat();
      case ($urandom_range(5))
         0: return 32'h0000_0000;
         1: return 32'h4000_0000;
         2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         3: return $urandom_range(32'h8000_0000) - 32'h4000_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(7))
         0: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         1, 2, 3: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
         default: return $urandom();
      endcase
   endfunction

   // receiver stall, changed on the falling edge
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // result checker and watchdog
   always @(posedge clock) begin
      xform_word_type exp_w;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d words outstanding",
                     expected_words.size());
            $display("[quaternion_point_transform_core] ERROR");
            $finish;
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
         if (rsp_clipped) clip_seen++;
         if (rsp_bad_rotation) bad_seen++;
         if (expected_words.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_out_x !== exp_w.x) begin
               $error("out_x exp %h got %h", exp_w.x, rsp_out_x); errors++;
            end
            if (rsp_out_y !== exp_w.y) begin
               $error("out_y exp %h got %h", exp_w.y, rsp_out_y); errors++;
            end
            if (rsp_out_z !== exp_w.z) begin
               $error("out_z exp %h got %h", exp_w.z, rsp_out_z); errors++;
            end
            if (rsp_out_intensity !== exp_w.inten) begin
               $error("out_intensity exp %h got %h", exp_w.inten, rsp_out_intensity);
               errors++;
            end
            if (rsp_bad_rotation !== exp_w.bad) begin
               $error("bad_rotation exp %b got %b", exp_w.bad, rsp_bad_rotation);
               errors++;
            end
            if (rsp_clipped !== exp_w.clip) begin
               $error("clipped exp %b got %b", exp_w.clip, rsp_clipped); errors++;
            end
         end
      end
   end

   // directed table: writes, then points with typed or predicted results
   row_type directed [] = '{
      // identity after reset, plain point and the field extremes
      '{0, 1, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 32'hdead_beef,
        32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 0, 0},
      '{0, 1, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
        32'h7fff_ffff, 32'h8000_0000, 32'h0, 0, 0},
      // translation pushes x past the top, then past the bottom
      '{1, 0, REG_SHIFT_X, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 1, 0, 0, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
        32'h7fff_ffff, 32'h0, 32'h0, 0, 1},
      '{1, 0, REG_SHIFT_X, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 1, 0, 0, 32'hffff_0000, 32'h0, 32'h0, 32'h0000_0001,
        32'h8000_0000, 32'h0, 32'h0, 0, 1},
      '{1, 0, REG_SHIFT_X, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, REG_SHIFT_Y, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, REG_SHIFT_Z, 32'hffff_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 1, 0, 0, 32'h0, 32'h0, 32'h0, 32'h5,
        32'h0, 32'h0001_0000, 32'hffff_0000, 0, 0},
      // all-zero quaternion, translation not applied
      '{1, 0, REG_QUAT_W, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 1, 0, 0, 32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_00a5,
        32'h0, 32'h0, 32'h0, 1, 0},
      // write past the register file is dropped
      '{1, 0, REG_NONE, 32'h4000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 1, 0, 0, 32'h0001_0000, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 1, 0},
      // half turn about z, then oversized components that get halved
      '{1, 0, REG_QUAT_Z, 32'h4000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h7, 0,0,0,0,0},
      '{1, 0, REG_QUAT_X, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, REG_QUAT_Y, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, REG_QUAT_W, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 0,0,0,0,0},
      '{0, 0, 0, 0, 32'hffff_8000, 32'h0000_8000, 32'h0, 32'h2, 0,0,0,0,0}
   };

   initial begin
      xform_word_type typed_w;
      for (int k = 0; k < 4; k++) quat_reg[k] = '0;
      quat_reg[3] = 32'h4000_0000;
      for (int k = 0; k < 3; k++) shift_reg[k] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 18;
      recv_idle_pct = 51;
      foreach (directed[r]) begin
         if (directed[r].is_wr) begin
            drain();
            write_reg(directed[r].idx, directed[r].data);
         end else begin
            typed_w = '{directed[r].ex, directed[r].ey, directed[r].ez,
                        directed[r].pi, directed[r].eb, directed[r].ec};
            send_point(directed[r].px, directed[r].py, directed[r].pz,
                       directed[r].pi, directed[r].typed, typed_w);
         end
      end

      // three phases of different idling, registers rewritten between segments
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 51 : 0;
         recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 18 : 0;
         for (int seg = 0; seg < PHASE_WORDS / SEG_WORDS; seg++) begin
            // sender holds off until the pipe is empty
            drain();
            for (int k = 0; k < 4; k++)
               if ($urandom_range(3) != 0) write_reg(CSR_IDX_BITS'(k), rand_quat());
            for (int k = 0; k < 3; k++)
               if ($urandom_range(2) != 0)
                  write_reg(CSR_IDX_BITS'(REG_SHIFT_X + k), $urandom_range(1) ? $urandom()
                            : $urandom_range(32'h0010_0000) - 32'h0008_0000);
            if ($urandom_range(7) == 0) write_reg(REG_NONE, $urandom());
            repeat (SEG_WORDS)
               send_point(rand_coord(), rand_coord(), rand_coord(), $urandom(),
                          0, '0);
         end
      end

      drain();
      repeat (10) @(posedge clock);
      $display("covered %0d point words, %0d register writes", words_sent, reg_writes);
      $display("results: %0d checked, %0d clipped, %0d with zero rotation",
               words_seen, clip_seen, bad_seen);
      if (errors == 0)
         $display("[quaternion_point_transform_core] OK");
      else
         $display("[quaternion_point_transform_core] ERROR");
      $finish;
   end

endmodule

[files.f]
src/qpt_pkg.sv
src/quaternion_point_transform_core.sv
sim/tb_top.sv
